// ----- hw/rtl/bslb_pkg.sv -----
// ----------------------------------------------------------------------------
// bslb_pkg
// Shared types and constants for the byte stream lexer with bracket check.
// ----------------------------------------------------------------------------
package bslb_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int POS_BITS_DEF    = 32;

	// Result queue geometry: one beat can produce up to three results.
	localparam int RQ_DEPTH  = 8;
	localparam int RQ_WR_MAX = 3;

	// Token kinds.
	localparam logic [3:0] TK_SEQ         = 4'd0;
	localparam logic [3:0] TK_COLON       = 4'd1;
	localparam logic [3:0] TK_EQUALS      = 4'd2;
	localparam logic [3:0] TK_IDENT       = 4'd3;
	localparam logic [3:0] TK_OPEN_CURLY  = 4'd4;
	localparam logic [3:0] TK_CLOSE_CURLY = 4'd7;
	localparam logic [3:0] TK_FAT_ARROW   = 4'd10;
	localparam logic [3:0] TK_THIN_ARROW  = 4'd11;

	// Error codes.
	localparam logic [2:0] ERR_BACKSLASH  = 3'd0;
	localparam logic [2:0] ERR_UNMATCHED  = 3'd1;
	localparam logic [2:0] ERR_MISMATCH   = 3'd2;
	localparam logic [2:0] ERR_UNKNOWN    = 3'd3;
	localparam logic [2:0] ERR_UNCLOSED   = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW   = 3'd5;

	// One result item as it leaves the block.
	typedef struct packed {
		logic        token_valid;
		logic [3:0]  token_kind;
		logic [31:0] span_start;
		logic [31:0] end_pos;
		logic        is_error;
		logic [2:0]  error_code;
		logic        source_done;
		logic        last;
	} res_t;

	// Bytes that may start an identifier.
	function automatic logic id_start(input logic [7:0] b);
		return (b == 8'h5F) || (b >= 8'h41 && b <= 8'h5A) ||
			(b >= 8'h61 && b <= 8'h7A) || b[7];
	endfunction

	// Bytes that may continue an identifier.
	function automatic logic id_cont(input logic [7:0] b);
		return id_start(b) || (b >= 8'h30 && b <= 8'h39);
	endfunction

endpackage

// ----- hw/rtl/bslb_res_queue.sv -----
// ----------------------------------------------------------------------------
// bslb_res_queue
// Small result queue: takes up to three results per cycle, gives one per beat.
// ----------------------------------------------------------------------------
module bslb_res_queue
	import bslb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] wr_cnt,
	input  res_t       wr_data [RQ_WR_MAX],
	output logic       space_ok,
	output logic       rd_valid,
	input  logic       rd_ready,
	output res_t       rd_data
);

	localparam int PW = $clog2(RQ_DEPTH);
	localparam int CW = $clog2(RQ_DEPTH + 1);

	res_t          slot_q [RQ_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign rd_valid = (cnt_q != '0);
	assign rd_data  = slot_q[rptr_q];
	assign pop      = rd_valid && rd_ready;
	assign space_ok = (cnt_q <= CW'(RQ_DEPTH - RQ_WR_MAX));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + PW'(wr_cnt);
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(wr_cnt) - CW'(pop);
		end
	end

	// Slot writes, in order from the write pointer.
	always_ff @(posedge clk) begin
		for (int i = 0; i < RQ_WR_MAX; i++) begin
			if (2'(i) < wr_cnt) begin
				slot_q[wptr_q + PW'(i)] <= wr_data[i];
			end
		end
	end

endmodule

// ----- hw/rtl/byte_stream_lexer_bracket_check.sv -----
// ----------------------------------------------------------------------------
// byte_stream_lexer_bracket_check
// Streaming lexer: tokens with byte spans, comment and blank skipping,
// line continuation and bracket nesting on a memory-held stack.
// ----------------------------------------------------------------------------
// Results are written into the result queue registers at their beat and shown on
// the master side once the results ahead of them have left. Throughput: one byte
// per cycle while the eight-entry result queue has three free slots; a byte can yield up to three results.
// The nesting stack lives in a one-port-read memory; the entry under the top
// is prefetched every cycle, so back-to-back closers run at full rate.
// Reset clears all control state; stack contents need no clearing.
// ----------------------------------------------------------------------------
module byte_stream_lexer_bracket_check
	import bslb_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int POS_BITS    = POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] byte_req
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] span_start, [63:32] end_pos
	output logic [9:0]  m_axis_tuser,   // [0] token_valid, [4:1] token_kind,
	                                    // [5] is_error, [8:6] error_code,
	                                    // [9] source_done
	output logic        m_axis_tlast
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int EW = POS_BITS + 2;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LCUR  = 8'h7B;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_LSQ   = 8'h5B;
	localparam logic [7:0] CH_RCUR  = 8'h7D;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_RSQ   = 8'h5D;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COMMENT,
		MODE_IDENT,
		MODE_EQ,
		MODE_DASH,
		MODE_HALT
	} mode_t;

	// Scanner state.
	mode_t               mode_q, mode_n;
	logic [POS_BITS-1:0] pos_q, pos_n;
	logic [POS_BITS-1:0] line_q, line_n;
	logic                cont_q, cont_n;
	logic [POS_BITS-1:0] contpos_q, contpos_n;
	logic [POS_BITS-1:0] ts_q, ts_n;
	logic [DW-1:0]       depth_q, depth_n;
	logic [EW-1:0]       top_q, top_n;

	// Stack memory and its prefetched entry under the top.
	logic [EW-1:0]       stack_mem [STACK_DEPTH];
	logic [EW-1:0]       below_q;
	logic [DW-1:0]       dm2;
	logic [AW-1:0]       raddr;
	logic                push;

	logic                accept;
	logic                space_ok;
	logic [7:0]          b;
	logic                eos;
	res_t                res_c [RQ_WR_MAX + 1];
	res_t                wr_data [RQ_WR_MAX];
	logic [2:0]          n;
	logic [1:0]          wr_cnt;
	res_t                head;

	assign s_axis_tready = space_ok;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;
	assign eos           = s_axis_tlast;

	function automatic res_t mk(input logic valid, input logic [3:0] kind,
		input logic [POS_BITS-1:0] s, input logic [POS_BITS-1:0] e,
		input logic err, input logic [2:0] code);
		res_t r;
		r.token_valid = valid;
		r.token_kind  = kind;
		r.span_start  = 32'(s);
		r.end_pos     = 32'(e);
		r.is_error    = err;
		r.error_code  = code;
		r.source_done = 1'b0;
		r.last        = 1'b0;
		return r;
	endfunction

	// Per-byte scan: next state and the list of results it causes.
	always_comb begin
		logic          do_idle;
		logic [1:0]    k_open;
		logic [1:0]    k_close;
		logic          is_open;
		logic          is_close;
		mode_n    = mode_q;
		pos_n     = pos_q;
		line_n    = line_q;
		cont_n    = cont_q;
		contpos_n = contpos_q;
		ts_n      = ts_q;
		depth_n   = depth_q;
		top_n     = top_q;
		push      = 1'b0;
		n         = 3'd0;
		do_idle   = 1'b0;
		for (int i = 0; i <= RQ_WR_MAX; i++) begin
			res_c[i] = '0;
		end
		is_open  = (b == CH_LCUR) || (b == CH_LPAR) || (b == CH_LSQ);
		k_open   = (b == CH_LCUR) ? 2'd0 : (b == CH_LPAR) ? 2'd1 : 2'd2;
		is_close = (b == CH_RCUR) || (b == CH_RPAR) || (b == CH_RSQ);
		k_close  = (b == CH_RCUR) ? 2'd0 : (b == CH_RPAR) ? 2'd1 : 2'd2;

		if (accept) begin
			if (mode_q == MODE_HALT) begin
				if (eos) begin
					mode_n    = MODE_IDLE;
					pos_n     = '0;
					line_n    = '0;
					cont_n    = 1'b0;
					contpos_n = '0;
					ts_n      = '0;
					depth_n   = '0;
				end
			end else begin
				// Close out a token that waited for this byte.
				unique case (mode_q)
					MODE_COMMENT: begin
						if (b == CH_LF) begin
							mode_n  = MODE_IDLE;
							do_idle = 1'b1;
						end
					end
					MODE_IDENT: begin
						if (!id_cont(b)) begin
							res_c[n[1:0]] = mk(1'b1, TK_IDENT, ts_q, pos_q, 1'b0, '0);
							n = n + 3'd1;
							mode_n  = MODE_IDLE;
							do_idle = 1'b1;
						end
					end
					MODE_EQ: begin
						mode_n = MODE_IDLE;
						if (b == CH_GT) begin
							res_c[n[1:0]] = mk(1'b1, TK_FAT_ARROW, ts_q,
								ts_q + POS_BITS'(2), 1'b0, '0);
						end else begin
							res_c[n[1:0]] = mk(1'b1, TK_EQUALS, ts_q,
								ts_q + POS_BITS'(1), 1'b0, '0);
							do_idle = 1'b1;
						end
						n = n + 3'd1;
					end
					MODE_DASH: begin
						mode_n = MODE_IDLE;
						if (b == CH_GT) begin
							res_c[n[1:0]] = mk(1'b1, TK_THIN_ARROW, ts_q,
								ts_q + POS_BITS'(2), 1'b0, '0);
						end else begin
							res_c[n[1:0]] = mk(1'b0, '0, ts_q,
								ts_q + POS_BITS'(1), 1'b1, ERR_UNKNOWN);
							mode_n = MODE_HALT;
						end
						n = n + 3'd1;
					end
					default: begin
						do_idle = 1'b1;
					end
				endcase

				// Byte seen from the idle scanner.
				if (do_idle) begin
					priority if (b == CH_HASH) begin
						mode_n = MODE_COMMENT;
					end else if (b == CH_SP || b == CH_TAB || b == CH_CR) begin
						mode_n = mode_n;
					end else if (b == CH_BSL) begin
						cont_n    = 1'b1;
						contpos_n = pos_q;
					end else if (b == CH_LF) begin
						if (!cont_q) begin
							res_c[n[1:0]] = mk(1'b1, TK_SEQ, line_q, pos_q, 1'b0, '0);
							n = n + 3'd1;
						end
						line_n = pos_q + POS_BITS'(1);
						cont_n = 1'b0;
					end else if (cont_q) begin
						res_c[n[1:0]] = mk(1'b0, '0, contpos_q,
							contpos_q + POS_BITS'(1), 1'b1, ERR_BACKSLASH);
						n = n + 3'd1;
						mode_n = MODE_HALT;
					end else if (b == CH_COLON) begin
						res_c[n[1:0]] = mk(1'b1, TK_COLON, pos_q,
							pos_q + POS_BITS'(1), 1'b0, '0);
						n = n + 3'd1;
					end else if (b == CH_SEMI) begin
						res_c[n[1:0]] = mk(1'b1, TK_SEQ, pos_q,
							pos_q + POS_BITS'(1), 1'b0, '0);
						n = n + 3'd1;
					end else if (b == CH_EQ) begin
						mode_n = MODE_EQ;
						ts_n   = pos_q;
					end else if (b == CH_DASH) begin
						mode_n = MODE_DASH;
						ts_n   = pos_q;
					end else if (id_start(b)) begin
						mode_n = MODE_IDENT;
						ts_n   = pos_q;
					end else if (is_open) begin
						if (depth_q >= DW'(STACK_DEPTH)) begin
							res_c[n[1:0]] = mk(1'b0, '0, pos_q,
								pos_q + POS_BITS'(1), 1'b1, ERR_OVERFLOW);
							mode_n = MODE_HALT;
						end else begin
							top_n   = {k_open, pos_q};
							depth_n = depth_q + DW'(1);
							push    = 1'b1;
							res_c[n[1:0]] = mk(1'b1, TK_OPEN_CURLY + 4'(k_open), pos_q,
								pos_q + POS_BITS'(1), 1'b0, '0);
						end
						n = n + 3'd1;
					end else if (is_close) begin
						if (depth_q == '0) begin
							res_c[n[1:0]] = mk(1'b0, '0, pos_q,
								pos_q + POS_BITS'(1), 1'b1, ERR_UNMATCHED);
							mode_n = MODE_HALT;
						end else if (top_q[EW-1:POS_BITS] != k_close) begin
							res_c[n[1:0]] = mk(1'b0, '0, top_q[POS_BITS-1:0],
								top_q[POS_BITS-1:0] + POS_BITS'(1), 1'b1, ERR_MISMATCH);
							mode_n = MODE_HALT;
						end else begin
							depth_n = depth_q - DW'(1);
							top_n   = below_q;
							res_c[n[1:0]] = mk(1'b1, TK_CLOSE_CURLY + 4'(k_close), pos_q,
								pos_q + POS_BITS'(1), 1'b0, '0);
						end
						n = n + 3'd1;
					end else begin
						res_c[n[1:0]] = mk(1'b0, '0, pos_q,
							pos_q + POS_BITS'(1), 1'b1, ERR_UNKNOWN);
						n = n + 3'd1;
						mode_n = MODE_HALT;
					end
				end

				// End of source: flush, check nesting, then clear the scanner.
				if (eos) begin
					if (mode_n == MODE_IDENT) begin
						res_c[n[1:0]] = mk(1'b1, TK_IDENT, ts_n,
							pos_q + POS_BITS'(1), 1'b0, '0);
						n = n + 3'd1;
					end else if (mode_n == MODE_EQ) begin
						res_c[n[1:0]] = mk(1'b1, TK_EQUALS, ts_n,
							ts_n + POS_BITS'(1), 1'b0, '0);
						n = n + 3'd1;
					end else if (mode_n == MODE_DASH) begin
						res_c[n[1:0]] = mk(1'b0, '0, ts_n,
							ts_n + POS_BITS'(1), 1'b1, ERR_UNKNOWN);
						n = n + 3'd1;
						mode_n = MODE_HALT;
					end
					if (mode_n != MODE_HALT && depth_n != '0) begin
						res_c[n[1:0]] = mk(1'b0, '0, top_n[POS_BITS-1:0],
							top_n[POS_BITS-1:0] + POS_BITS'(1), 1'b1, ERR_UNCLOSED);
						n = n + 3'd1;
					end
					if (n == 3'd0) begin
						n = 3'd1;
					end
					res_c[2'(n - 3'd1)].source_done = 1'b1;
					mode_n    = MODE_IDLE;
					pos_n     = '0;
					line_n    = '0;
					cont_n    = 1'b0;
					contpos_n = '0;
					ts_n      = '0;
					depth_n   = '0;
				end else begin
					pos_n = pos_q + POS_BITS'(1);
				end
				if (n != 3'd0) begin
					res_c[2'(n - 3'd1)].last = 1'b1;
				end
			end
		end
	end

	// Read address: the entry that will sit under the top next cycle.
	assign dm2   = depth_n - DW'(2);
	assign raddr = (depth_n >= DW'(2)) ? dm2[AW-1:0] : '0;

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			pos_q     <= '0;
			line_q    <= '0;
			cont_q    <= 1'b0;
			contpos_q <= '0;
			ts_q      <= '0;
			depth_q   <= '0;
		end else begin
			mode_q    <= mode_n;
			pos_q     <= pos_n;
			line_q    <= line_n;
			cont_q    <= cont_n;
			contpos_q <= contpos_n;
			ts_q      <= ts_n;
			depth_q   <= depth_n;
		end
	end

	// Stack top register and the stack memory.
	always_ff @(posedge clk) begin
		top_q   <= top_n;
		below_q <= stack_mem[raddr];
		if (push) begin
			stack_mem[depth_q[AW-1:0]] <= top_n;
		end
	end

	// Results into the output queue.
	always_comb begin
		for (int i = 0; i < RQ_WR_MAX; i++) begin
			wr_data[i] = res_c[i];
		end
	end
	assign wr_cnt = 2'(n);

	bslb_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (wr_cnt),
		.wr_data  (wr_data),
		.space_ok (space_ok),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_data  (head)
	);

	// Master-side beat fields.
	assign m_axis_tdata = {head.end_pos, head.span_start};
	assign m_axis_tuser = {head.source_done, head.error_code, head.is_error,
		head.token_kind, head.token_valid};
	assign m_axis_tlast = head.last;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte stream lexer with bracket check. Sources
// are built from random lexemes, with some noise bytes mixed in. Every byte
// beat goes through a lexer predictor held in a scoreboard class, and every
// result beat is compared field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
	import bslb_pkg::*;

	localparam int NEST_MAX = 64;

	// Scan states of the predictor.
	typedef enum logic [2:0] {
		SCAN_IDLE, SCAN_COMMENT, SCAN_IDENT, SCAN_EQ, SCAN_DASH, SCAN_HALT
	} scan_t;

	// Lexer predictor and queue of expected results.
	class lexer_scoreboard;
		res_t        pending[$];
		logic [1:0]  nest_kind[NEST_MAX];
		logic [31:0] nest_pos[NEST_MAX];
		int          depth;
		logic [31:0] pos, line_start, cont_pos, tok_start;
		bit          cont;
		scan_t       scan;
		int          errors;
		res_t        burst[$];

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			depth = 0;
			pos = 0;
			line_start = 0;
			cont = 0;
			cont_pos = 0;
			scan = SCAN_IDLE;
			tok_start = 0;
		endfunction

		function void emit(bit valid, logic [3:0] kind, logic [31:0] s, logic [31:0] e,
				bit err, logic [2:0] code);
			res_t r;
			r = '0;
			r.token_valid = valid;
			r.token_kind = kind;
			r.span_start = s;
			r.end_pos = e;
			r.is_error = err;
			r.error_code = code;
			burst = {burst, r};
		endfunction

		function void raise(logic [2:0] code, logic [31:0] s);
			scan = SCAN_HALT;
			emit(0, TK_SEQ, s, s + 1, 1, code);
		endfunction

		function bit ident_first(logic [7:0] b);
			return b == "_" || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b[7];
		endfunction

		function void lex_idle(logic [7:0] b, logic [31:0] p);
			int k;
			if (b == "#") begin
				scan = SCAN_COMMENT;
				return;
			end
			if (b == " " || b == 8'h09 || b == 8'h0D) return;
			if (b == "\\") begin
				cont = 1;
				cont_pos = p;
				return;
			end
			if (b == 8'h0A) begin
				if (!cont) emit(1, TK_SEQ, line_start, p, 0, ERR_BACKSLASH);
				line_start = p + 1;
				cont = 0;
				return;
			end
			if (cont) begin
				raise(ERR_BACKSLASH, cont_pos);
				return;
			end
			if (b == ":") begin
				emit(1, TK_COLON, p, p + 1, 0, ERR_BACKSLASH);
				return;
			end
			if (b == ";") begin
				emit(1, TK_SEQ, p, p + 1, 0, ERR_BACKSLASH);
				return;
			end
			if (b == "=" || b == "-" || ident_first(b)) begin
				scan = (b == "=") ? SCAN_EQ : (b == "-") ? SCAN_DASH : SCAN_IDENT;
				tok_start = p;
				return;
			end
			k = (b == "{") ? 0 : (b == "(") ? 1 : (b == "[") ? 2 : 3;
			if (k < 3) begin
				if (depth >= NEST_MAX) begin
					raise(ERR_OVERFLOW, p);
					return;
				end
				nest_kind[depth] = 2'(k);
				nest_pos[depth] = p;
				depth++;
				emit(1, TK_OPEN_CURLY + 4'(k), p, p + 1, 0, ERR_BACKSLASH);
				return;
			end
			k = (b == "}") ? 0 : (b == ")") ? 1 : (b == "]") ? 2 : 3;
			if (k < 3) begin
				if (depth == 0) raise(ERR_UNMATCHED, p);
				else if (nest_kind[depth - 1] != 2'(k)) raise(ERR_MISMATCH, nest_pos[depth - 1]);
				else begin
					depth--;
					emit(1, TK_CLOSE_CURLY + 4'(k), p, p + 1, 0, ERR_BACKSLASH);
				end
				return;
			end
			raise(ERR_UNKNOWN, p);
		endfunction

		// Note one accepted byte beat and queue what it should produce.
		function void note_byte(logic [7:0] b, bit eos);
			logic [31:0] p;
			p = pos;
			burst.delete();
			if (scan == SCAN_HALT) begin
				if (eos) clear();
				return;
			end
			case (scan)
				SCAN_COMMENT: if (b == 8'h0A) begin
					scan = SCAN_IDLE;
					lex_idle(b, p);
				end
				SCAN_IDENT: if (!(ident_first(b) || (b >= "0" && b <= "9"))) begin
					emit(1, TK_IDENT, tok_start, p, 0, ERR_BACKSLASH);
					scan = SCAN_IDLE;
					lex_idle(b, p);
				end
				SCAN_EQ: begin
					scan = SCAN_IDLE;
					if (b == ">") emit(1, TK_FAT_ARROW, tok_start, tok_start + 2, 0, ERR_BACKSLASH);
					else begin
						emit(1, TK_EQUALS, tok_start, tok_start + 1, 0, ERR_BACKSLASH);
						lex_idle(b, p);
					end
				end
				SCAN_DASH: begin
					scan = SCAN_IDLE;
					if (b == ">") emit(1, TK_THIN_ARROW, tok_start, tok_start + 2, 0,
						ERR_BACKSLASH);
					else raise(ERR_UNKNOWN, tok_start);
				end
				default: lex_idle(b, p);
			endcase
			if (eos) begin
				if (scan == SCAN_IDENT) emit(1, TK_IDENT, tok_start, p + 1, 0, ERR_BACKSLASH);
				else if (scan == SCAN_EQ)
					emit(1, TK_EQUALS, tok_start, tok_start + 1, 0, ERR_BACKSLASH);
				else if (scan == SCAN_DASH) raise(ERR_UNKNOWN, tok_start);
				if (scan != SCAN_HALT && depth > 0) raise(ERR_UNCLOSED, nest_pos[depth - 1]);
				if (burst.size() == 0) emit(0, TK_SEQ, 0, 0, 0, ERR_BACKSLASH);
				burst[$].source_done = 1;
				clear();
			end else pos = p + 1;
			if (burst.size() > 0) burst[$].last = 1;
			foreach (burst[i]) pending = {pending, burst[i]};
		endfunction

		// Compare one result beat against the oldest expectation.
		function void check_result(res_t got);
			res_t exp;
			if (pending.size() == 0) begin
				$error("result beat with no expectation waiting");
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.token_valid !== exp.token_valid) fail_field("token_valid", exp.token_valid, got.token_valid);
			if (got.token_kind !== exp.token_kind) fail_field("token_kind", exp.token_kind, got.token_kind);
			if (got.span_start !== exp.span_start) fail_field("span_start", exp.span_start, got.span_start);
			if (got.end_pos !== exp.end_pos) fail_field("end_pos", exp.end_pos, got.end_pos);
			if (got.is_error !== exp.is_error) fail_field("is_error", exp.is_error, got.is_error);
			if (got.error_code !== exp.error_code) fail_field("error_code", exp.error_code, got.error_code);
			if (got.source_done !== exp.source_done) fail_field("source_done", exp.source_done, got.source_done);
			if (got.last !== exp.last) fail_field("last", exp.last, got.last);
		endfunction

		function void fail_field(string name, logic [31:0] exp, logic [31:0] got);
			$error("%s mismatch: expected %0h, got %0h", name, exp, got);
			errors++;
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [63:0] m_axis_tdata;
	logic [9:0]  m_axis_tuser;
	logic        m_axis_tlast;

	lexer_scoreboard lexer_sb = new();
	bit          hold_off = 0;
	bit          stim_done = 0;
	logic [7:0]  src_bytes[$];
	int          stack_fill;

	byte_stream_lexer_bracket_check DUT (.*);

	always #4 clk = ~clk;

	// Record accepted beats on both sides at each rising edge.
	always @(posedge clk) begin
		res_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) lexer_sb.note_byte(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			r.span_start = m_axis_tdata[31:0];
			r.end_pos = m_axis_tdata[63:32];
			r.token_valid = m_axis_tuser[0];
			r.token_kind = m_axis_tuser[4:1];
			r.is_error = m_axis_tuser[5];
			r.error_code = m_axis_tuser[8:6];
			r.source_done = m_axis_tuser[9];
			r.last = m_axis_tlast;
			lexer_sb.check_result(r);
		end
	end

	// Receiver stall pattern, with one long hold-off on request.
	always @(posedge clk) begin
		int phase;
		phase = $urandom_range(0, 99);
		if (hold_off) m_axis_tready <= 0;
		else if (stim_done) m_axis_tready <= 1;
		else m_axis_tready <= (phase < 70) || ((lexer_sb.pos % 97) > 60);
	end

	// Send one byte beat, waiting for the handshake.
	task automatic send_byte(logic [7:0] b, bit eos);
		s_axis_tvalid <= 1;
		s_axis_tdata <= b;
		s_axis_tlast <= eos;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Send a source held in src_bytes, in bursts with gaps when gaps is set; the final byte ends it.
	task automatic send_source(bit gaps);
		int burst_left;
		burst_left = $urandom_range(1, 12);
		foreach (src_bytes[i]) begin
			send_byte(src_bytes[i], i == src_bytes.size() - 1);
			if (gaps && --burst_left == 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
		s_axis_tvalid <= 0;
		src_bytes.delete();
	endtask

	// Append one byte to the source under construction.
	task automatic add_byte(logic [7:0] v);
		src_bytes = {src_bytes, v};
	endtask

	task automatic add_text(string s);
		foreach (s[i]) add_byte(s[i]);
	endtask

	// Append one random lexeme, mostly well formed.
	task automatic add_lexeme();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A)) :
				8'($urandom_range(8'h80, 8'hFF)));
			repeat ($urandom_range(0, 4)) add_byte($urandom_range(0, 1) ?
				8'($urandom_range(8'h30, 8'h39)) : 8'($urandom_range(8'h41, 8'h5A)));
			add_byte(" ");
		end else if (pick < 35) begin
			add_byte("(");
			stack_fill++;
		end else if (pick < 50 && stack_fill > 0) begin
			add_byte(")");
			stack_fill--;
		end else if (pick < 60) add_text(":");
		else if (pick < 66) add_text(" => ");
		else if (pick < 72) add_text("->");
		else if (pick < 77) add_text("= ");
		else if (pick < 83) add_text("\n");
		else if (pick < 86) add_text("# note\n");
		else if (pick < 89) add_text("\\\t\r\n");
		else if (pick < 92) add_text(";");
		else add_byte(8'($urandom_range(0, 255)));
	endtask

	// Wait until every expected result has arrived.
	task automatic drain();
		while (lexer_sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed sources: each operation and special case.
		add_text("a_Z9: x = y => z -> w;\n{([])}\n");
		add_byte(8'hFF);
		add_byte(8'h80);
		add_text("=");
		send_source(0);
		add_text("a \\ \n b \\ \\ x");
		send_source(1);
		add_text("ok # trailing");
		send_source(0);
		add_text("{]");
		send_source(0);
		add_text(")");
		send_source(0);
		add_text("9");
		send_source(0);
		add_text("-x ignored ) still");
		send_source(0);
		add_text("-");
		send_source(0);
		add_text("([ \\");
		send_source(0);
		add_byte(8'h00);
		send_source(0);
		repeat (65) add_text("[");
		add_text("abc");
		send_source(0);
		drain();

		// Long receiver hold-off while bytes keep coming.
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			begin
				repeat (40) add_text("a:");
				send_source(0);
			end
		join
		drain();

		// Random sources of well-formed lexemes with noise.
		for (int n = 0; n < 9; n++) begin
			stack_fill = 0;
			repeat ($urandom_range(4, 16)) add_lexeme();
			if ($urandom_range(0, 3) != 0) repeat (stack_fill) add_byte(")");
			send_source(1);
			if (n % 4 == 3) drain();
		end
		stim_done = 1;
		drain();
		repeat (20) @(posedge clk);
		if (lexer_sb.errors == 0 && lexer_sb.pending.size() == 0)
			$display("byte_stream_lexer_bracket_check verification clean");
		else
			$display("byte_stream_lexer_bracket_check verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("byte_stream_lexer_bracket_check verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bslb_pkg.sv
hw/rtl/bslb_res_queue.sv
hw/rtl/byte_stream_lexer_bracket_check.sv
test/testbench.sv
